/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the stable priority queue
// Transaction payloads, operation and status codes, cell link types.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned OccW   = 5;

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic signed [PrioW-1:0]  prio_t;
  typedef logic [OccW-1:0]          occ_t;

  typedef struct packed {
    action_e action;
    value_t  entry_value;
    prio_t   entry_priority;
  } in_t;

  typedef struct packed {
    status_e status;
    value_t  removed_value;
    occ_t    occupancy;
  } out_t;

  // Operation broadcast to every cell in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    prio_t    key;
    value_t   value;
  } cell_cmd_t;

  // What a cell shows its neighbours
  typedef struct packed {
    logic   valid;
    logic   greater;  // valid and priority number above the broadcast key
    value_t value;
    prio_t  prio;
  } slot_t;

endpackage

/* sv/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry; on insert it keeps, shifts right or takes the new entry,
// on remove it takes its right neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::cell_cmd_t cmd_i,
  input  spq_pkg::slot_t    left_i,
  input  spq_pkg::slot_t    right_i,
  output spq_pkg::slot_t    slot_o
);

  logic            valid_q, valid_d;
  spq_pkg::value_t value_q, value_d;
  spq_pkg::prio_t  prio_q, prio_d;
  logic            greater;

  assign greater = valid_q && (prio_q > cmd_i.key);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    case (cmd_i.op)
      spq_pkg::CELL_INSERT: begin
        valid_d = valid_q | left_i.valid;
        if (left_i.greater) begin
          // new entry lands further left: shift back by one
          value_d = left_i.value;
          prio_d  = left_i.prio;
        end else if (left_i.valid && (greater || !valid_q)) begin
          value_d = cmd_i.value;
          prio_d  = cmd_i.key;
        end
      end
      spq_pkg::CELL_REMOVE: begin
        valid_d = right_i.valid;
        value_d = right_i.value;
        prio_d  = right_i.prio;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign slot_o = '{valid: valid_q, greater: greater, value: value_q, prio: prio_q};

endmodule

/* sv/stable_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue_top: bounded priority queue as a row of sorting cells
// Each transaction in is an insert or a remove of the head entry; each gives
// one result transaction out with status, removed value and occupancy.
//
// Entries live in a row of CAPACITY cells kept in priority order, cell 0
// being the head. A lower priority number is served first and equal numbers
// leave in arrival order. Every cell compares the broadcast key with its own
// entry in parallel and either keeps it, passes it one cell back, or takes
// the new entry; the cells and the result register are written on the same
// edge. The input is taken in the same cycle as the result register drains,
// giving a sustained rate of one transaction per clock while out_ready_i is high.
// An insert into a full queue is dropped with status full, a remove on an
// empty queue returns status empty; removed_value is zero unless a remove
// succeeds. Occupancy is the fill count after the transaction, reduced to
// its five bits.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spq_pkg::out_t out_data_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                in_fire;
  logic                is_full, is_empty;
  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q;
  spq_pkg::out_t       out_q, out_d;
  spq_pkg::cell_cmd_t  cmd;

  spq_pkg::slot_t      slot_out [CAPACITY];
  spq_pkg::slot_t      left_in  [CAPACITY];
  spq_pkg::slot_t      right_in [CAPACITY];
  logic [CAPACITY-1:0] vld;

  // Result register drains in the cycle a new transaction is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_full  = (count_q == CntW'(CAPACITY));
  assign is_empty = (count_q == '0);

  always_comb begin
    cmd.op    = spq_pkg::CELL_HOLD;
    cmd.key   = in_data_i.entry_priority;
    cmd.value = in_data_i.entry_value;
    count_d   = count_q;
    out_d.status        = spq_pkg::ST_OK;
    out_d.removed_value = '0;
    if (in_data_i.action == spq_pkg::ACT_INSERT) begin
      if (is_full) begin
        out_d.status = spq_pkg::ST_FULL;
      end else begin
        cmd.op  = in_fire ? spq_pkg::CELL_INSERT : spq_pkg::CELL_HOLD;
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (is_empty) begin
        out_d.status = spq_pkg::ST_EMPTY;
      end else begin
        cmd.op              = in_fire ? spq_pkg::CELL_REMOVE : spq_pkg::CELL_HOLD;
        count_d             = count_q - CntW'(1);
        out_d.removed_value = slot_out[0].value;
      end
    end
    out_d.occupancy = spq_pkg::occ_t'(count_d);
  end

  // Cell row: the head sees an always-valid, never-greater left neighbour,
  // the tail an empty right neighbour.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_in[i] = '{valid: 1'b1, greater: 1'b0, value: '0, prio: '0};
    end else begin : g_body
      assign left_in[i] = slot_out[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_in[i] = '{valid: 1'b0, greater: 1'b0, value: '0, prio: '0};
    end else begin : g_inner
      assign right_in[i] = slot_out[i+1];
    end

    spq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left_in[i]),
      .right_i (right_in[i]),
      .slot_o  (slot_out[i])
    );

    assign vld[i] = slot_out[i].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // Valid cells and the fill count agree
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld) == int'(count_q))
    else $error("cell valid bits disagree with fill count");

  // Valid cells form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld >> 1) & ~vld) == '0)
    else $error("gap in valid cells");

  // A dropped insert leaves the fill count alone
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.action == spq_pkg::ACT_INSERT && is_full)
    |=> (count_q == $past(count_q)) && (out_q.status == spq_pkg::ST_FULL))
    else $error("insert into full queue changed state");

  // A successful remove returns what the head held
  a_remove_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.action == spq_pkg::ACT_REMOVE && !is_empty)
    |=> (out_q.removed_value == $past(slot_out[0].value))
        && (out_q.status == spq_pkg::ST_OK))
    else $error("removed value differs from head entry");
`endif

endmodule
